// ===== design/afp_pkg.sv =====
// ----------------------------------------------------------------------------
// afp_pkg
// Shared types and constants for the AT data frame parser.
// ----------------------------------------------------------------------------
package afp_pkg;

    localparam int MAX_PAYLOAD_DEF = 256;

    localparam int ACC_W = 17;

    localparam logic       CMD_BYTE  = 1'b0;
    localparam logic       CMD_ABORT = 1'b1;

    localparam logic [1:0] CLASS_ACK   = 2'd0;
    localparam logic [1:0] CLASS_JSON  = 2'd1;
    localparam logic [1:0] CLASS_OTHER = 2'd2;

    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_I      = 8'h49;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_D      = 8'h44;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam logic [7:0] ACK_B0 = 8'h40;
    localparam logic [7:0] ACK_B1 = 8'h02;
    localparam logic [7:0] ACK_B2 = 8'h00;
    localparam logic [7:0] ACK_B3 = 8'h0A;

    localparam logic [2:0] MAX_DIGITS = 3'd5;

    typedef struct packed {
        logic       cmd;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic [8:0] frame_length;
        logic       is_last;
        logic [1:0] frame_class;
    } out_item_t;

endpackage

// ===== design/afp_in_reg.sv =====
// ----------------------------------------------------------------------------
// afp_in_reg
// Input register: holds one accepted item until the parser consumes it.
// ----------------------------------------------------------------------------
module afp_in_reg
    import afp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  in_item_t in_item,
    input  logic     take,
    output logic     held_valid,
    output in_item_t held_item
);

    logic     valid_reg;
    in_item_t item_reg;
    logic     load;

    assign load       = in_valid && !in_stall;
    assign in_stall   = valid_reg && !take;
    assign held_valid = valid_reg;
    assign held_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= in_item;
        end
    end

endmodule

// ===== design/afp_parser.sv =====
// ----------------------------------------------------------------------------
// afp_parser
// Header hunt, length decode and payload tracking; one item per fire.
// ----------------------------------------------------------------------------
module afp_parser
    import afp_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      fire,
    input  in_item_t  item,
    output logic      res_valid,
    output out_item_t res_item
);

    localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_PLUS  = 3'd1;
    localparam logic [2:0] PH_I     = 3'd2;
    localparam logic [2:0] PH_P     = 3'd3;
    localparam logic [2:0] PH_D     = 3'd4;
    localparam logic [2:0] PH_AFTER = 3'd5;
    localparam logic [2:0] PH_LEN   = 3'd6;
    localparam logic [2:0] PH_RECV  = 3'd7;

    logic [2:0]       phase_reg,  phase_next;
    logic [ACC_W-1:0] acc_reg,    acc_next;
    logic [2:0]       digits_reg, digits_next;
    logic [LEN_W-1:0] len_reg,    len_next;
    logic [LEN_W-1:0] count_reg,  count_next;
    logic             ack_reg,    ack_next;
    logic             brace_reg,  brace_next;

    logic [7:0]       b;
    logic             is_digit;
    logic [3:0]       digit;
    logic [ACC_W-1:0] acc_mac;
    logic [15:0]      len16;
    logic             len_bad;
    logic [LEN_W-1:0] count_inc;
    logic             last;
    logic             ack_now;
    logic             brace_now;
    logic [7:0]       ack_ref;
    logic [1:0]       cls;

    assign b        = item.rx_byte;
    assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    assign digit    = b[3:0];
    assign acc_mac  = ACC_W'({acc_reg, 3'b000}) + ACC_W'({acc_reg, 1'b0}) + ACC_W'(digit);
    assign len16    = acc_reg[15:0];
    assign len_bad  = (digits_reg == 3'd0) || (len16 == 16'd0)
                      || (32'(len16) > MAX_PAYLOAD);
    assign count_inc = count_reg + LEN_W'(1);
    assign last      = count_inc >= len_reg;

    always_comb
    begin
        unique case (count_reg[1:0])
            2'd0:    ack_ref = ACK_B0;
            2'd1:    ack_ref = ACK_B1;
            2'd2:    ack_ref = ACK_B2;
            default: ack_ref = ACK_B3;
        endcase
    end

    assign ack_now   = ack_reg && !((32'(count_reg) < 4) && (b != ack_ref));
    assign brace_now = brace_reg || (b == CH_LBRACE);

    always_comb
    begin
        priority if (!last)
        begin
            cls = CLASS_ACK;
        end
        else if ((32'(len_reg) == 4) && ack_now)
        begin
            cls = CLASS_ACK;
        end
        else if ((32'(len_reg) >= 10) && (32'(len_reg) <= 255) && brace_now)
        begin
            cls = CLASS_JSON;
        end
        else
        begin
            cls = CLASS_OTHER;
        end
    end

    assign res_valid             = fire && (item.cmd == CMD_BYTE) && (phase_reg == PH_RECV);
    assign res_item.payload_byte = b;
    assign res_item.frame_length = 9'(len_reg);
    assign res_item.is_last      = last;
    assign res_item.frame_class  = cls;

    always_comb
    begin
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        digits_next = digits_reg;
        len_next    = len_reg;
        count_next  = count_reg;
        ack_next    = ack_reg;
        brace_next  = brace_reg;
        if (item.cmd == CMD_ABORT)
        begin
            phase_next  = PH_IDLE;
            acc_next    = '0;
            digits_next = '0;
            len_next    = '0;
            count_next  = '0;
            ack_next    = 1'b1;
            brace_next  = 1'b0;
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (b == CH_PLUS)
                    begin
                        phase_next = PH_PLUS;
                    end
                end
                PH_PLUS:  phase_next = (b == CH_I) ? PH_I : PH_IDLE;
                PH_I:     phase_next = (b == CH_P) ? PH_P : PH_IDLE;
                PH_P:     phase_next = (b == CH_D) ? PH_D : PH_IDLE;
                PH_D:     phase_next = (b == CH_COMMA) ? PH_AFTER : PH_IDLE;
                PH_AFTER:
                begin
                    if (is_digit)
                    begin
                        acc_next    = ACC_W'(digit);
                        digits_next = 3'd1;
                        phase_next  = PH_LEN;
                    end
                    else
                    begin
                        phase_next  = PH_IDLE;
                        acc_next    = '0;
                        digits_next = '0;
                    end
                end
                PH_LEN:
                begin
                    priority if (is_digit && (digits_reg < MAX_DIGITS))
                    begin
                        acc_next    = acc_mac;
                        digits_next = digits_reg + 3'd1;
                    end
                    else if (b == CH_COLON)
                    begin
                        digits_next = '0;
                        acc_next    = '0;
                        if (len_bad)
                        begin
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            len_next   = LEN_W'(len16);
                            count_next = '0;
                            ack_next   = 1'b1;
                            brace_next = 1'b0;
                            phase_next = PH_RECV;
                        end
                    end
                    else if (b == CH_COMMA)
                    begin
                        digits_next = '0;
                        acc_next    = '0;
                    end
                    else
                    begin
                        phase_next  = PH_IDLE;
                        acc_next    = '0;
                        digits_next = '0;
                    end
                end
                default:
                begin
                    if (last)
                    begin
                        phase_next = PH_IDLE;
                        len_next   = '0;
                        count_next = '0;
                        ack_next   = 1'b1;
                        brace_next = 1'b0;
                    end
                    else
                    begin
                        count_next = count_inc;
                        ack_next   = ack_now;
                        brace_next = brace_now;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            acc_reg    <= '0;
            digits_reg <= '0;
            len_reg    <= '0;
            count_reg  <= '0;
            ack_reg    <= 1'b1;
            brace_reg  <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            acc_reg    <= acc_next;
            digits_reg <= digits_next;
            len_reg    <= len_next;
            count_reg  <= count_next;
            ack_reg    <= ack_next;
            brace_reg  <= brace_next;
        end
    end

endmodule

// ===== design/afp_out_reg.sv =====
// ----------------------------------------------------------------------------
// afp_out_reg
// Result register: holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module afp_out_reg
    import afp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  out_item_t load_item,
    output logic      ready,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_item
);

    logic      valid_reg;
    out_item_t item_reg;

    assign ready     = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && ready)
        begin
            item_reg <= load_item;
        end
    end

endmodule

// ===== design/at_data_frame_parser_top.sv =====
// ----------------------------------------------------------------------------
// at_data_frame_parser_top
// Path: input register, then combinational parser, then result register.
// Throughput: one item per cycle; the result register sets the pace under stall.
// Reset: rst_n clears the parser to idle with no item held; no clearing pass.
// Hunts "+IPD,<len>:" and streams payload bytes with length, last mark, class.
// ----------------------------------------------------------------------------
module at_data_frame_parser_top
    import afp_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_item
);

    logic      held_valid;
    in_item_t  held_item;
    logic      out_ready;
    logic      fire;
    logic      res_valid;
    out_item_t res_item;

    assign fire = held_valid && out_ready;

    afp_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .take       (fire),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    afp_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item      (held_item),
        .res_valid (res_valid),
        .res_item  (res_item)
    );

    afp_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .load_item (res_item),
        .ready     (out_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule
